// ===== sv/siao_pkg.sv =====
// Shared types and constants for the sized integer ALU.
`timescale 1ns / 1ps
package siao_pkg;

  // Width of the item fields on the ports
  localparam int FIELD_BITS = 32;
  // Width of a clamped operand size in bytes (holds up to 15)
  localparam int SZ_W = 4;
  // One byte of ones, the unit of a size mask
  localparam logic [7:0] BYTE_ONES = 8'o377;

  typedef enum logic [3:0] {
    OP_MUL = 4'd0,
    OP_DIV = 4'd1,
    OP_MOD = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_LT  = 4'd5,
    OP_GT  = 4'd6,
    OP_LE  = 4'd7,
    OP_GE  = 4'd8,
    OP_EQ  = 4'd9,
    OP_NE  = 4'd10,
    OP_AND = 4'd11,
    OP_OR  = 4'd12,
    OP_NEG = 4'd13,
    OP_NOT = 4'd14
  } op_t;

  // Control that travels with each item down the pipe
  typedef struct packed {
    op_t             op;
    logic            uns;
    logic            sym;
    logic            a_neg;
    logic            diff;
    logic [SZ_W-1:0] sz;
    logic            ovf;
    logic            dz;
  } ctl_t;

endpackage

// ===== sv/siao_front.sv =====
// Front stages: operand reduction, ALU and product, multiply overflow.
`timescale 1ns / 1ps
module siao_front #(
  parameter int W = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [3:0]                          operation,
  input  logic                                is_unsigned,
  input  logic [2:0]                          size_bytes,
  input  logic [siao_pkg::FIELD_BITS-1:0]     operand_a,
  input  logic [siao_pkg::FIELD_BITS-1:0]     operand_b,
  input  logic                                sym,
  output logic                                s3_valid,
  output siao_pkg::ctl_t                      s3_ctl,
  output logic [W-1:0]                        s3_r,
  output logic [W-1:0]                        s3_ma,
  output logic [W-1:0]                        s3_mb
);

  localparam int MAXB = W / 8;

  function automatic logic [W-1:0] size_mask(input logic [siao_pkg::SZ_W-1:0] sz);
    logic [W-1:0] m;
    m = '0;
    for (int i = 0; i < MAXB; i++) begin
      if (siao_pkg::SZ_W'(i) < sz) m[8*i +: 8] = siao_pkg::BYTE_ONES;
    end
    return m;
  endfunction

  // mask in unsigned mode, sign-extend from the size in signed mode
  function automatic logic [W-1:0] reduce(input logic [W-1:0] x, input logic [W-1:0] m,
                                          input logic uns);
    logic [W-1:0] xm;
    logic         sb;
    xm = x & m;
    sb = |(xm & ~(m >> 1));
    return (!uns && sb) ? (xm | ~m) : xm;
  endfunction

  // ---------------- stage 1: decode and reduce ----------------
  logic [siao_pkg::SZ_W-1:0] sz_c;
  logic [W-1:0]              mask_c, a_c, b_c, ma_c, mb_c;
  logic                      an_c, bn_c;
  siao_pkg::op_t             op_c;

  always_comb begin
    sz_c = siao_pkg::SZ_W'(size_bytes);
    if (sz_c == '0) sz_c = siao_pkg::SZ_W'(1);
    else if (sz_c > siao_pkg::SZ_W'(MAXB)) sz_c = siao_pkg::SZ_W'(MAXB);
    mask_c = size_mask(sz_c);
    a_c    = reduce(W'(operand_a), mask_c, is_unsigned);
    b_c    = reduce(W'(operand_b), mask_c, is_unsigned);
    an_c   = !is_unsigned && a_c[W-1];
    bn_c   = !is_unsigned && b_c[W-1];
    ma_c   = an_c ? -a_c : a_c;
    mb_c   = bn_c ? -b_c : b_c;
    op_c   = siao_pkg::op_t'(operation);
  end

  logic           v1;
  siao_pkg::ctl_t ctl1;
  logic [W-1:0]   a1, b1, ma1, mb1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1.op    <= op_c;
      ctl1.uns   <= is_unsigned;
      ctl1.sym   <= sym;
      ctl1.a_neg <= an_c;
      ctl1.diff  <= an_c ^ bn_c;
      ctl1.sz    <= sz_c;
      ctl1.ovf   <= 1'b0;
      ctl1.dz    <= (op_c == siao_pkg::OP_DIV || op_c == siao_pkg::OP_MOD) && (b_c == '0);
      a1  <= a_c;
      b1  <= b_c;
      ma1 <= ma_c;
      mb1 <= mb_c;
    end
  end

  // ---------------- stage 2: ALU and magnitude product ----------------
  logic [W-1:0]          mask2, mx2, r2_c, lim2_c;
  logic signed [W+1:0]   sa, sb, sum, dif, mxs, mn;
  logic                  ovf2_c;
  siao_pkg::ctl_t        ctl2_c;

  always_comb begin
    mask2 = size_mask(ctl1.sz);
    mx2   = mask2 >> 1;
    sa    = ctl1.uns ? $signed({2'b00, a1}) : $signed({{2{a1[W-1]}}, a1});
    sb    = ctl1.uns ? $signed({2'b00, b1}) : $signed({{2{b1[W-1]}}, b1});
    sum   = sa + sb;
    dif   = sa - sb;
    mxs   = $signed({2'b00, mx2});
    mn    = ctl1.sym ? -mxs : -mxs - $signed((W+2)'(1));
    r2_c  = '0;
    ovf2_c = 1'b0;
    case (ctl1.op)
      siao_pkg::OP_ADD: begin
        r2_c = a1 + b1;
        if (ctl1.uns) ovf2_c = sum > $signed({2'b00, mask2});
        else ovf2_c = (sa > 0 && sb > 0 && sum > mxs) || (sa < 0 && sb < 0 && sum < mn);
      end
      siao_pkg::OP_SUB: begin
        r2_c = a1 - b1;
        if (ctl1.uns) ovf2_c = b1 > a1;
        else ovf2_c = (sa >= 0 && sb < 0 && dif > mxs) || (sa < 0 && sb >= 0 && dif < mn);
      end
      siao_pkg::OP_LT:  r2_c = W'(sa < sb);
      siao_pkg::OP_GT:  r2_c = W'(sa > sb);
      siao_pkg::OP_LE:  r2_c = W'(sa <= sb);
      siao_pkg::OP_GE:  r2_c = W'(sa >= sb);
      siao_pkg::OP_EQ:  r2_c = W'(sa == sb);
      siao_pkg::OP_NE:  r2_c = W'(sa != sb);
      siao_pkg::OP_AND: r2_c = W'((a1 != '0) && (b1 != '0));
      siao_pkg::OP_OR:  r2_c = W'((a1 != '0) || (b1 != '0));
      siao_pkg::OP_NOT: r2_c = W'(a1 == '0);
      siao_pkg::OP_NEG: begin
        r2_c   = -a1;
        ovf2_c = !ctl1.uns && !ctl1.sym && (sa == mn);
      end
      default: r2_c = '0;
    endcase
    // product limit: full mask, or the signed bound on the side of the sign
    if (ctl1.uns) lim2_c = mask2;
    else if (ctl1.diff && !ctl1.sym) lim2_c = mx2 + W'(1);
    else lim2_c = mx2;
    ctl2_c     = ctl1;
    ctl2_c.ovf = ovf2_c;
  end

  logic           v2;
  siao_pkg::ctl_t ctl2;
  logic [W-1:0]   r2, lim2, ma2, mb2;
  logic [2*W-1:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2  <= ctl2_c;
      r2    <= r2_c;
      lim2  <= lim2_c;
      ma2   <= ma1;
      mb2   <= mb1;
      prod2 <= (2*W)'(ma1) * (2*W)'(mb1);
    end
  end

  // ---------------- stage 3: multiply result and overflow ----------------
  siao_pkg::ctl_t ctl3_c;
  logic [W-1:0]   r3_c;

  always_comb begin
    ctl3_c = ctl2;
    r3_c   = r2;
    if (ctl2.op == siao_pkg::OP_MUL) begin
      ctl3_c.ovf = prod2 > {{W{1'b0}}, lim2};
      r3_c       = ctl2.diff ? -prod2[W-1:0] : prod2[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl <= ctl3_c;
      s3_r   <= r3_c;
      s3_ma  <= ma2;
      s3_mb  <= mb2;
    end
  end

endmodule

// ===== sv/siao_div_step.sv =====
// One restoring division step: one quotient bit per stage.
`timescale 1ns / 1ps
module siao_div_step #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           v_in,
  input  siao_pkg::ctl_t ctl_in,
  input  logic [W-1:0]   r_in,
  input  logic [W-1:0]   mb_in,
  input  logic [W-1:0]   rem_in,
  input  logic [W-1:0]   nq_in,
  output logic           v_out,
  output siao_pkg::ctl_t ctl_out,
  output logic [W-1:0]   r_out,
  output logic [W-1:0]   mb_out,
  output logic [W-1:0]   rem_out,
  output logic [W-1:0]   nq_out
);

  logic [W:0]   t, t_sub;
  logic         ge;
  logic [W-1:0] rem_next, nq_next;

  // shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    t        = {rem_in, nq_in[W-1]};
    t_sub    = t - {1'b0, mb_in};
    ge       = t >= {1'b0, mb_in};
    rem_next = ge ? t_sub[W-1:0] : t[W-1:0];
    nq_next  = {nq_in[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl_in;
      r_out   <= r_in;
      mb_out  <= mb_in;
      rem_out <= rem_next;
      nq_out  <= nq_next;
    end
  end

endmodule

// ===== sv/siao_back.sv =====
// Back stage: division sign fix-up, size masking and output register.
`timescale 1ns / 1ps
module siao_back #(
  parameter int W = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            v_in,
  input  siao_pkg::ctl_t                  ctl_in,
  input  logic [W-1:0]                    r_in,
  input  logic [W-1:0]                    mb_in,
  input  logic [W-1:0]                    rem_in,
  input  logic [W-1:0]                    q_in,
  output logic                            out_valid,
  output logic [siao_pkg::FIELD_BITS-1:0] result_bits,
  output logic                            overflow,
  output logic                            divide_by_zero
);

  localparam int MAXB = W / 8;

  function automatic logic [W-1:0] size_mask(input logic [siao_pkg::SZ_W-1:0] sz);
    logic [W-1:0] m;
    m = '0;
    for (int i = 0; i < MAXB; i++) begin
      if (siao_pkg::SZ_W'(i) < sz) m[8*i +: 8] = siao_pkg::BYTE_ONES;
    end
    return m;
  endfunction

  logic [W-1:0]                    r_c, mask_c, rm_c, fw_c;
  logic                            rem_nz, sbit;
  logic [siao_pkg::FIELD_BITS-1:0] res_c;

  // floor division and divisor-signed modulo from the magnitudes
  always_comb begin
    rem_nz = rem_in != '0;
    r_c    = r_in;
    case (ctl_in.op)
      siao_pkg::OP_DIV: begin
        if (ctl_in.uns || !ctl_in.diff) r_c = q_in;
        else r_c = -(q_in + W'(rem_nz));
      end
      siao_pkg::OP_MOD: begin
        if (ctl_in.uns) r_c = rem_in;
        else if (rem_nz && ctl_in.diff) r_c = ctl_in.a_neg ? mb_in - rem_in : rem_in - mb_in;
        else r_c = ctl_in.a_neg ? -rem_in : rem_in;
      end
      default: r_c = r_in;
    endcase
    if (ctl_in.dz) r_c = '0;
    mask_c = size_mask(ctl_in.sz);
    rm_c   = r_c & mask_c;
    sbit   = |(rm_c & ~(mask_c >> 1));
    fw_c   = (!ctl_in.uns && sbit) ? (rm_c | ~mask_c) : rm_c;
  end

  // widen or cut to the port, signed results keep their sign
  generate
    if (W >= siao_pkg::FIELD_BITS) begin : g_cut
      assign res_c = fw_c[siao_pkg::FIELD_BITS-1:0];
    end else begin : g_ext
      assign res_c = ctl_in.uns ? siao_pkg::FIELD_BITS'(fw_c)
                                : {{(siao_pkg::FIELD_BITS-W){fw_c[W-1]}}, fw_c};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_bits    <= res_c;
      overflow       <= ctl_in.ovf;
      divide_by_zero <= ctl_in.dz;
    end
  end

endmodule

// ===== sv/sized_integer_alu_with_overflow.sv =====
// Top level of the pipelined sized integer ALU with overflow flags.
//
// Usage: an item (operation, is_unsigned, size_bytes, operand_a, operand_b)
// is taken at a clock edge with in_valid high and in_stall low. Each item
// gives exactly one result (result_bits, overflow, divide_by_zero), offered
// with out_valid and taken at an edge where out_stall is low.
// symmetric_range is written through cfg_valid/cfg_ready; cfg_ready is
// always high, and the register should only change while the pipe is empty.
// Pipeline: three front stages for reduction, ALU/product and multiply
// overflow, one stage per quotient bit of the restoring divider, and the
// output register.
// Throughput: one item per cycle unless stalled; every op passes the same stages.
// Stall: while a result waits with out_stall high, the whole pipe holds and
// in_stall is raised; bubbles still move up behind an empty output.
// Reset (rst, synchronous) clears all valid bits and symmetric_range.
`timescale 1ns / 1ps
module sized_integer_alu_with_overflow #(
  parameter int DATA_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [3:0]                      operation,
  input  logic                            is_unsigned,
  input  logic [2:0]                      size_bytes,
  input  logic [siao_pkg::FIELD_BITS-1:0] operand_a,
  input  logic [siao_pkg::FIELD_BITS-1:0] operand_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [siao_pkg::FIELD_BITS-1:0] result_bits,
  output logic                            overflow,
  output logic                            divide_by_zero,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            symmetric_range
);

  localparam int W = DATA_BITS;

  logic en;
  logic sym;

  // pipe moves unless a finished item is held by the receiver
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) sym <= 1'b0;
    else if (cfg_valid && cfg_ready) sym <= symmetric_range;
  end

  // divider chain taps, index 0 is the front end's output
  logic           d_v   [W+1];
  siao_pkg::ctl_t d_ctl [W+1];
  logic [W-1:0]   d_r   [W+1];
  logic [W-1:0]   d_mb  [W+1];
  logic [W-1:0]   d_rem [W+1];
  logic [W-1:0]   d_nq  [W+1];

  siao_front #(.W(W)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .operation   (operation),
    .is_unsigned (is_unsigned),
    .size_bytes  (size_bytes),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .sym         (sym),
    .s3_valid    (d_v[0]),
    .s3_ctl      (d_ctl[0]),
    .s3_r        (d_r[0]),
    .s3_ma       (d_nq[0]),
    .s3_mb       (d_mb[0])
  );

  assign d_rem[0] = '0;

  generate
    for (genvar g = 0; g < W; g++) begin : g_div
      siao_div_step #(.W(W)) u_step (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .v_in    (d_v[g]),
        .ctl_in  (d_ctl[g]),
        .r_in    (d_r[g]),
        .mb_in   (d_mb[g]),
        .rem_in  (d_rem[g]),
        .nq_in   (d_nq[g]),
        .v_out   (d_v[g+1]),
        .ctl_out (d_ctl[g+1]),
        .r_out   (d_r[g+1]),
        .mb_out  (d_mb[g+1]),
        .rem_out (d_rem[g+1]),
        .nq_out  (d_nq[g+1])
      );
    end
  endgenerate

  siao_back #(.W(W)) u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .v_in           (d_v[W]),
    .ctl_in         (d_ctl[W]),
    .r_in           (d_r[W]),
    .mb_in          (d_mb[W]),
    .rem_in         (d_rem[W]),
    .q_in           (d_nq[W]),
    .out_valid      (out_valid),
    .result_bits    (result_bits),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  // a zero divisor always yields a clean zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_bits == '0 && !overflow)
    else $error("divide by zero result not cleared");

  // a held result must freeze the input side
  a_hold_stalls_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output held");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an item that reached the output under a stall stays there
  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held item lost");

endmodule
